// ===== design/tristate_ook_remote_switch_encoder_assert.svh =====
`ifndef TRISTATE_OOK_REMOTE_SWITCH_ENCODER_ASSERT_SVH
`define TRISTATE_OOK_REMOTE_SWITCH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TORS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define TORS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tors_pkg.sv =====
package tors_pkg;

  localparam logic [3:0] SYNC_SYMBOL = 4'd12;
  localparam logic [1:0] SYNC_LAST_SEG = 2'd1;
  localparam logic [1:0] DATA_LAST_SEG = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SHORT_TICKS    = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS     = 2'd1;
  localparam logic [1:0] REG_SYNC_GAP_TICKS = 2'd2;
  localparam logic [1:0] REG_REPEAT_COUNT   = 2'd3;

  localparam logic [11:0] SHORT_TICKS_RESET    = 12'd320;
  localparam logic [11:0] LONG_TICKS_RESET     = 12'd900;
  localparam logic [13:0] SYNC_GAP_TICKS_RESET = 14'd10000;
  localparam logic [3:0]  REPEAT_COUNT_RESET   = 4'd6;

  typedef struct packed {
    logic [11:0] short_ticks;
    logic [11:0] long_ticks;
    logic [13:0] sync_gap_ticks;
    logic [3:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    logic tx_level;
    logic tx_enable;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

// ===== design/tristate_ook_remote_switch_encoder.sv =====
// Channel  Signals                                      Direction  Word moved when
// in       in_valid, in_stall, op, house_code,          to block   in_valid && !in_stall
//          switch_number, power_on
// out      out_valid, out_stall, tx_level, tx_enable,   from block out_valid && !out_stall
//          busy_res, frame_done
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    to block   cfg_valid && cfg_ready
//
// One word per cycle while the output does not stall: each input word is held in the
// input register, the tick or start step runs in a single pass and its result lands
// in the output register.
// A stall on the output holds the result register and, once it is filled, the input
// register; in_stall rises only while both are full.
// Synchronous reset empties both registers, clears the burst state and loads the
// default timing registers.
module tristate_ook_remote_switch_encoder import tors_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [4:0]  house_code,
  input  logic [2:0]  switch_number,
  input  logic        power_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_level,
  output logic        tx_enable,
  output logic        busy_res,
  output logic        frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  cfg_t        cfg;
  result_t     step_result;
  result_t     out_reg;
  logic        s1_valid;
  logic        s1_op;
  logic [4:0]  s1_house;
  logic [2:0]  s1_switch;
  logic        s1_power;
  logic        advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks    <= SHORT_TICKS_RESET;
      cfg.long_ticks     <= LONG_TICKS_RESET;
      cfg.sync_gap_ticks <= SYNC_GAP_TICKS_RESET;
      cfg.repeat_count   <= REPEAT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT_TICKS:    cfg.short_ticks    <= cfg_data[11:0];
        REG_LONG_TICKS:     cfg.long_ticks     <= cfg_data[11:0];
        REG_SYNC_GAP_TICKS: cfg.sync_gap_ticks <= cfg_data;
        REG_REPEAT_COUNT:   cfg.repeat_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The input word moves on whenever the output register is empty or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op     <= op;
      s1_house  <= house_code;
      s1_switch <= switch_number;
      s1_power  <= power_on;
    end
  end

  tors_step u_step (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .op            (s1_op),
    .house_code    (s1_house),
    .switch_number (s1_switch),
    .power_on      (s1_power),
    .cfg           (cfg),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= step_result;
    end
  end

  assign tx_level   = out_reg.tx_level;
  assign tx_enable  = out_reg.tx_enable;
  assign busy_res   = out_reg.busy_res;
  assign frame_done = out_reg.frame_done;

`include "tristate_ook_remote_switch_encoder_assert.svh"

  `TORS_ASSERT_NOW(a_stall_needs_word, in_stall, s1_valid && out_valid,
                   "input stalled without a held word")
  `TORS_ASSERT_NEXT(a_advance_fills_out, advance, out_valid,
                    "result register not loaded after advance")
  `TORS_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_reg),
                    "stalled result word changed")

endmodule

// ===== design/tors_step.sv =====
module tors_step import tors_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic       op,
  input  logic [4:0] house_code,
  input  logic [2:0] switch_number,
  input  logic       power_on,
  input  cfg_t       cfg,
  output result_t    result
);

  logic [4:0]  house_reg, house_reg_next;
  logic [2:0]  switch_reg, switch_reg_next;
  logic        power_reg, power_reg_next;
  logic [3:0]  repeat_counter, repeat_counter_next;
  logic [3:0]  symbol_index, symbol_index_next;
  logic [1:0]  segment_index, segment_index_next;
  logic [13:0] duration_counter, duration_counter_next;
  logic        active, active_next;
  logic        level_reg, level_reg_next;

  logic        load;
  logic        done;
  logic [13:0] dur_dec;
  logic [1:0]  last_seg;
  logic [3:0]  rc_inc;
  logic [3:0]  rep_eff;
  logic        sym_zero;
  logic [13:0] seg_len;

  // True when the data symbol about to be loaded is '0' rather than 'F'.
  always_comb begin
    sym_zero = !power_reg_next;
    if (symbol_index_next < 4'd5) begin
      sym_zero = house_reg_next[3'(4'd4 - symbol_index_next)];
    end else if (symbol_index_next < 4'd10) begin
      sym_zero = ((symbol_index_next - 4'd4) == {1'b0, switch_reg_next});
    end else if (symbol_index_next == 4'd10) begin
      sym_zero = power_reg_next;
    end
  end

  always_comb begin
    if (symbol_index_next == SYNC_SYMBOL) begin
      seg_len = (segment_index_next == 2'd0) ? {2'b00, cfg.short_ticks}
                                             : cfg.sync_gap_ticks;
    end else if (segment_index_next < 2'd2) begin
      seg_len = (segment_index_next == 2'd0) ? {2'b00, cfg.short_ticks}
                                             : {2'b00, cfg.long_ticks};
    end else if (sym_zero == (segment_index_next == 2'd2)) begin
      seg_len = {2'b00, cfg.short_ticks};
    end else begin
      seg_len = {2'b00, cfg.long_ticks};
    end
  end

  assign dur_dec  = duration_counter - 14'd1;
  assign last_seg = (symbol_index == SYNC_SYMBOL) ? SYNC_LAST_SEG : DATA_LAST_SEG;
  assign rc_inc   = repeat_counter + 4'd1;
  assign rep_eff  = (cfg.repeat_count == 4'd0) ? 4'd1 : cfg.repeat_count;

  always_comb begin
    house_reg_next        = house_reg;
    switch_reg_next       = switch_reg;
    power_reg_next        = power_reg;
    repeat_counter_next   = repeat_counter;
    symbol_index_next     = symbol_index;
    segment_index_next    = segment_index;
    duration_counter_next = duration_counter;
    active_next           = active;
    level_reg_next        = level_reg;
    load                  = 1'b0;
    done                  = 1'b0;
    if (go) begin
      if (op) begin
        if (!active) begin
          house_reg_next      = house_code;
          switch_reg_next     = switch_number;
          power_reg_next      = power_on;
          repeat_counter_next = 4'd0;
          symbol_index_next   = 4'd0;
          segment_index_next  = 2'd0;
          active_next         = 1'b1;
          load                = 1'b1;
        end
      end else if (active) begin
        duration_counter_next = dur_dec;
        if (dur_dec == 14'd0) begin
          if (segment_index < last_seg) begin
            segment_index_next = segment_index + 2'd1;
            load               = 1'b1;
          end else if (symbol_index < SYNC_SYMBOL) begin
            symbol_index_next  = symbol_index + 4'd1;
            segment_index_next = 2'd0;
            load               = 1'b1;
          end else begin
            repeat_counter_next = rc_inc;
            symbol_index_next   = 4'd0;
            segment_index_next  = 2'd0;
            if (rc_inc >= rep_eff) begin
              active_next    = 1'b0;
              level_reg_next = 1'b0;
              done           = 1'b1;
            end else begin
              load = 1'b1;
            end
          end
        end
      end
    end
    if (load) begin
      // Even segments are carrier on; a zero length counts as one tick.
      level_reg_next        = !segment_index_next[0];
      duration_counter_next = (seg_len == 14'd0) ? 14'd1 : seg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      house_reg        <= '0;
      switch_reg       <= '0;
      power_reg        <= 1'b0;
      repeat_counter   <= '0;
      symbol_index     <= '0;
      segment_index    <= '0;
      duration_counter <= '0;
      active           <= 1'b0;
      level_reg        <= 1'b0;
    end else begin
      house_reg        <= house_reg_next;
      switch_reg       <= switch_reg_next;
      power_reg        <= power_reg_next;
      repeat_counter   <= repeat_counter_next;
      symbol_index     <= symbol_index_next;
      segment_index    <= segment_index_next;
      duration_counter <= duration_counter_next;
      active           <= active_next;
      level_reg        <= level_reg_next;
    end
  end

  assign result.tx_level   = level_reg_next;
  assign result.tx_enable  = active_next;
  assign result.busy_res   = active_next;
  assign result.frame_done = done;

`include "tristate_ook_remote_switch_encoder_assert.svh"

  `TORS_ASSERT_NOW(a_idle_carrier_off, !active, !level_reg, "carrier on while idle")
  `TORS_ASSERT_NOW(a_duration_live, active, duration_counter != 14'd0,
                   "active with empty segment")
  `TORS_ASSERT_NOW(a_sync_segments, active && (symbol_index == SYNC_SYMBOL),
                   segment_index <= SYNC_LAST_SEG, "sync symbol past its gap")
  `TORS_ASSERT_NEXT(a_start_loads, go && op && !active,
                    active && level_reg && (symbol_index == 4'd0),
                    "start did not load the first high segment")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tors_pkg::*;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int          HOLD_OFF_CYCLES = 60;
  localparam int          RANDOM_PHASES   = 4;
  localparam int          PHASE_WORDS     = 50;

  // Mirrors the encoder: burst state, timing registers and the results still owed.
  class burst_scoreboard;
    cfg_t        cfg;
    logic [4:0]  house_q;
    logic [2:0]  switch_q;
    logic        power_q;
    logic [3:0]  frames_sent;
    logic [3:0]  sym;
    logic [1:0]  seg;
    logic [13:0] ticks_left;
    bit          running;
    bit          level;
    result_t     owed_results[$];
    int          errors;
    int          words_in;

    function new();
      cfg.short_ticks    = SHORT_TICKS_RESET;
      cfg.long_ticks     = LONG_TICKS_RESET;
      cfg.sync_gap_ticks = SYNC_GAP_TICKS_RESET;
      cfg.repeat_count   = REPEAT_COUNT_RESET;
      house_q = '0;
      switch_q = '0;
      power_q = 1'b0;
      frames_sent = '0;
      sym = '0;
      seg = '0;
      ticks_left = '0;
      running = 1'b0;
      level = 1'b0;
      errors = 0;
      words_in = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [13:0] value);
      case (idx)
        REG_SHORT_TICKS: cfg.short_ticks = value[11:0];
        REG_LONG_TICKS: cfg.long_ticks = value[11:0];
        REG_SYNC_GAP_TICKS: cfg.sync_gap_ticks = value;
        REG_REPEAT_COUNT: cfg.repeat_count = value[3:0];
        default: ;
      endcase
    endfunction

    // True when the data symbol is '0', false when it is 'F'.
    function bit sends_zero(logic [3:0] s);
      if (s < 4'd5) return house_q[4 - int'(s)];
      if (s < 4'd10) return (int'(s) - 4) == int'(switch_q);
      if (s == 4'd10) return power_q;
      return !power_q;
    endfunction

    function void load_segment();
      logic [13:0] len;
      level = !seg[0];
      if (sym == SYNC_SYMBOL) begin
        len = (seg == 2'd0) ? {2'b00, cfg.short_ticks} : cfg.sync_gap_ticks;
      end else if (seg < 2'd2) begin
        len = (seg == 2'd0) ? {2'b00, cfg.short_ticks} : {2'b00, cfg.long_ticks};
      end else if (sends_zero(sym)) begin
        len = (seg == 2'd2) ? {2'b00, cfg.short_ticks} : {2'b00, cfg.long_ticks};
      end else begin
        len = (seg == 2'd2) ? {2'b00, cfg.long_ticks} : {2'b00, cfg.short_ticks};
      end
      // A zero length still lasts one tick.
      ticks_left = (len == '0) ? 14'd1 : len;
    endfunction

    function void note_word(logic w_op, logic [4:0] w_house, logic [2:0] w_switch,
                            logic w_power);
      bit      done;
      logic [1:0] last_seg;
      logic [3:0] frames_wanted;
      result_t r;
      done = 1'b0;
      words_in++;
      if (w_op == OP_START) begin
        if (!running) begin
          house_q = w_house;
          switch_q = w_switch;
          power_q = w_power;
          frames_sent = '0;
          sym = '0;
          seg = '0;
          running = 1'b1;
          load_segment();
        end
      end else if (running) begin
        ticks_left = ticks_left - 14'd1;
        if (ticks_left == '0) begin
          last_seg = (sym == SYNC_SYMBOL) ? SYNC_LAST_SEG : DATA_LAST_SEG;
          if (seg < last_seg) begin
            seg = seg + 2'd1;
            load_segment();
          end else if (sym < SYNC_SYMBOL) begin
            sym = sym + 4'd1;
            seg = '0;
            load_segment();
          end else begin
            frames_sent = frames_sent + 4'd1;
            frames_wanted = (cfg.repeat_count == '0) ? 4'd1 : cfg.repeat_count;
            sym = '0;
            seg = '0;
            if (frames_sent >= frames_wanted) begin
              running = 1'b0;
              level = 1'b0;
              done = 1'b1;
            end else begin
              load_segment();
            end
          end
        end
      end
      r.tx_level = level;
      r.tx_enable = running;
      r.busy_res = running;
      r.frame_done = done;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic lvl, logic en, logic bsy, logic done);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result word, actual level %0b enable %0b busy %0b done %0b",
                 $time, lvl, en, bsy, done);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("tx_level", want.tx_level, lvl);
      compare_field("tx_enable", want.tx_enable, en);
      compare_field("busy_res", want.busy_res, bsy);
      compare_field("frame_done", want.frame_done, done);
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function bit in_burst();
      return running;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [4:0]  house_code;
  logic [2:0]  switch_number;
  logic        power_on;
  logic        out_valid;
  logic        out_stall;
  logic        tx_level;
  logic        tx_enable;
  logic        busy_res;
  logic        frame_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_data;

  burst_scoreboard sb = new();
  bit              holding_off = 1'b0;
  bit              pressure_done = 1'b0;
  int unsigned     cycle_count = 0;

  tristate_ook_remote_switch_encoder DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .house_code(house_code),
    .switch_number(switch_number),
    .power_on(power_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_level(tx_level),
    .tx_enable(tx_enable),
    .busy_res(busy_res),
    .frame_done(frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int random_pause(int pct_none);
    int r;
    r = $urandom_range(0, 99);
    if (r < pct_none) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_word(logic w_op, logic [4:0] w_house, logic [2:0] w_switch,
                           logic w_power);
    int gap;
    in_valid <= 1'b1;
    op <= w_op;
    house_code <= w_house;
    switch_number <= w_switch;
    power_on <= w_power;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w_op, w_house, w_switch, w_power);
    @(negedge clk);
    gap = holding_off ? 0 : random_pause(55);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic tick_until_idle();
    while (sb.in_burst()) send_tick();
  endtask

  task automatic run_burst(logic [4:0] h, logic [2:0] s, logic p);
    send_word(OP_START, h, s, p);
    tick_until_idle();
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [13:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_timing(logic [13:0] short_len, logic [13:0] long_len,
                              logic [13:0] gap_len, logic [13:0] frames);
    write_register(REG_SHORT_TICKS, short_len);
    write_register(REG_LONG_TICKS, long_len);
    write_register(REG_SYNC_GAP_TICKS, gap_len);
    write_register(REG_REPEAT_COUNT, frames);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_word(tx_level, tx_enable, busy_res, frame_done);
    end
  end

  // Output side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int free_run;
    int stall_run;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      free_run = $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (free_run) @(negedge clk);
      if (!pressure_done && sb.words_in > 120) begin
        holding_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        holding_off = 1'b0;
        pressure_done = 1'b1;
      end else begin
        stall_run = random_pause(60);
        if (stall_run > 0) begin
          out_stall <= 1'b1;
          repeat (stall_run) @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic wants_start;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_TICK;
    house_code = '0;
    switch_number = '0;
    power_on = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SHORT_TICKS;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ticks with no burst running change nothing.
    send_tick();
    send_tick();
    wait_results_done();

    write_timing(14'd1, 14'd2, 14'd3, 14'd1);
    send_word(OP_START, 5'd31, 3'd1, 1'b1);
    // A start during a burst must be ignored.
    send_word(OP_START, 5'd0, 3'd5, 1'b0);
    tick_until_idle();
    run_burst(5'd0, 3'd5, 1'b0);
    wait_results_done();
    write_register(REG_REPEAT_COUNT, 14'd2);
    run_burst(5'd21, 3'd0, 1'b1);
    run_burst(5'd10, 3'd6, 1'b0);
    run_burst(5'd0, 3'd7, 1'b1);
    wait_results_done();

    // Values above the register widths keep only their low bits, here all zero,
    // so every segment lasts one tick and one frame is sent.
    write_timing(14'd4096, 14'd12288, 14'd1, 14'd16);
    run_burst(5'd16, 3'd3, 1'b0);
    wait_results_done();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_timing(14'($urandom_range(0, 3)), 14'($urandom_range(0, 4)),
                   14'($urandom_range(0, 6)), 14'($urandom_range(0, 3)));
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (!sb.in_burst()) wants_start = ($urandom_range(0, 3) != 0);
        else wants_start = ($urandom_range(0, 24) == 0);
        if (wants_start) begin
          send_word(OP_START, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
        end else begin
          send_tick();
        end
      end
      wait_results_done();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
